/* sv/mrs_pkg.sv */
// Shared types, constants and the CRC-16 byte step for the register slave.
// No dependencies; mrs_ctrl, mrs_dp, the top level and the testbench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package mrs_pkg;

   localparam int PAGES_DEFAULT       = 16;
   localparam int PAGE_WORDS_DEFAULT  = 256;
   localparam int FRAME_BYTES_DEFAULT = 256;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int COUNT_W = 9;
   localparam int WORDS_W = 8;        // words a frame can carry, at most 123
   localparam int HDR_BYTES = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ID      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_ENABLE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FRAME_LEN = 2'd2;

   localparam logic [7:0] FC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FC_READ_INPUT   = 8'h04;
   localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_SHORT    = 3'd1;
   localparam logic [2:0] STAT_CRC      = 3'd2;
   localparam logic [2:0] STAT_ID       = 3'd3;
   localparam logic [2:0] STAT_FUNC     = 3'd4;
   localparam logic [2:0] STAT_UNMAPPED = 3'd5;
   localparam logic [2:0] STAT_OVERFLOW = 3'd6;
   localparam logic [2:0] STAT_BEYOND   = 3'd7;

   typedef enum logic [1:0] {
      OP_FRAME_BYTE = 2'd0,
      OP_LOAD       = 2'd1,
      OP_STORE      = 2'd2,
      OP_NONE       = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_HDR_REQ, S_HDR_CAP, S_EVAL, S_WORD_HI, S_WORD_LO,
      S_WORD_WR, S_LOCAL, S_LOAD_WAIT, S_RESULT
   } state_type;

   typedef struct packed {
      logic accept;
      logic check;
      logic hdr_rd;
      logic hdr_cap;
      logic eval;
      logic word_hi;
      logic word_lo;
      logic word_wr;
      logic local_op;
      logic load_cap;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      opcode_type in_op;
      logic       in_last;
      logic       early_bad;
      logic       eval_write;
      logic       hdr_done;
      logic       word_done;
      logic       local_load;
      logic       out_free;
   } sts_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0] data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* sv/mrs_if.sv */
// Channel interfaces: request, response and register write channel.
// Depends on nothing but the valid/ready convention.
`timescale 1ns / 1ps
`default_nettype none
interface mrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  frame_byte;
   logic        last_of_frame;
   logic [15:0] address;
   logic [15:0] write_word;
   modport source (output valid, opcode, frame_byte, last_of_frame, address, write_word,
                   input ready);
   modport sink (input valid, opcode, frame_byte, last_of_frame, address, write_word,
                 output ready);
endinterface

interface mrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] read_word;
   modport source (output valid, status, read_word, input ready);
   modport sink (input valid, status, read_word, output ready);
endinterface

interface mrs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/mrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* sv/mrs_ctrl.sv */
// Controller state machine: sequences byte intake, frame checks, word writes
// and local accesses. Depends on mrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire mrs_pkg::sts_type sts,
   output      mrs_pkg::cmd_type cmd
);
   mrs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         mrs_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (sts.in_op)
                  mrs_pkg::OP_FRAME_BYTE: state_in = sts.in_last ? mrs_pkg::S_CHECK
                                                                 : mrs_pkg::S_IDLE;
                  mrs_pkg::OP_LOAD:       state_in = mrs_pkg::S_LOCAL;
                  mrs_pkg::OP_STORE:      state_in = mrs_pkg::S_LOCAL;
                  default:                state_in = mrs_pkg::S_IDLE;
               endcase
            end
         end
         mrs_pkg::S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.early_bad ? mrs_pkg::S_RESULT : mrs_pkg::S_HDR_REQ;
         end
         mrs_pkg::S_HDR_REQ: begin
            cmd.hdr_rd = 1'b1;
            state_in   = mrs_pkg::S_HDR_CAP;
         end
         mrs_pkg::S_HDR_CAP: begin
            cmd.hdr_cap = 1'b1;
            state_in    = sts.hdr_done ? mrs_pkg::S_EVAL : mrs_pkg::S_HDR_REQ;
         end
         mrs_pkg::S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.eval_write ? mrs_pkg::S_WORD_HI : mrs_pkg::S_RESULT;
         end
         mrs_pkg::S_WORD_HI: begin
            cmd.word_hi = 1'b1;
            state_in    = mrs_pkg::S_WORD_LO;
         end
         mrs_pkg::S_WORD_LO: begin
            cmd.word_lo = 1'b1;
            state_in    = mrs_pkg::S_WORD_WR;
         end
         mrs_pkg::S_WORD_WR: begin
            cmd.word_wr = 1'b1;
            state_in    = sts.word_done ? mrs_pkg::S_RESULT : mrs_pkg::S_WORD_HI;
         end
         mrs_pkg::S_LOCAL: begin
            cmd.local_op = 1'b1;
            state_in     = sts.local_load ? mrs_pkg::S_LOAD_WAIT : mrs_pkg::S_RESULT;
         end
         mrs_pkg::S_LOAD_WAIT: begin
            cmd.load_cap = 1'b1;
            state_in     = mrs_pkg::S_RESULT;
         end
         mrs_pkg::S_RESULT: begin
            if (sts.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = mrs_pkg::S_IDLE;
            end
         end
         default: state_in = mrs_pkg::S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* sv/mrs_dp.sv */
// Datapath: config registers, frame buffer, CRC, header checks, paged
// register store and the result register. Depends on mrs_pkg and mrs_ram.
`timescale 1ns / 1ps
`default_nettype none
module mrs_dp #(
   parameter int PAGES       = mrs_pkg::PAGES_DEFAULT,
   parameter int PAGE_WORDS  = mrs_pkg::PAGE_WORDS_DEFAULT,
   parameter int FRAME_BYTES = mrs_pkg::FRAME_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mrs_pkg::cmd_type                cmd,
   output      mrs_pkg::sts_type                sts,
   input  wire logic [1:0]                      req_opcode,
   input  wire logic [7:0]                      req_frame_byte,
   input  wire logic                            req_last_of_frame,
   input  wire logic [15:0]                     req_address,
   input  wire logic [15:0]                     req_write_word,
   input  wire logic                            rsp_ready,
   output      logic                            rsp_valid,
   output      logic [2:0]                      rsp_status,
   output      logic [15:0]                     rsp_read_word,
   input  wire logic                            csr_valid,
   input  wire logic [mrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mrs_pkg::CSR_DATA_W-1:0]  csr_data
);
   localparam int FA_W = $clog2(FRAME_BYTES);
   localparam int RA_W = $clog2(PAGES * PAGE_WORDS);

   logic [7:0]  slave_id_ff, min_len_ff;
   logic [15:0] page_en_ff;

   logic [mrs_pkg::COUNT_W-1:0] count_ff;
   logic [15:0]                 crc_ff;
   logic                        is_frame_ff;
   mrs_pkg::opcode_type         op_ff;
   logic [15:0]                 addr_ff, wword_ff;

   logic [2:0]  hidx_ff;
   logic [7:0]  hdr_ff [mrs_pkg::HDR_BYTES];
   logic [FA_W-1:0] ptr_ff;
   logic [RA_W-1:0] ra_ff;
   logic [mrs_pkg::WORDS_W-1:0] wleft_ff;
   logic [7:0]  hi_ff;
   logic [2:0]  stat_ff;
   logic [15:0] word_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_stat_ff;
   logic [15:0] rsp_word_ff;

   logic [7:0]  frd;
   logic [15:0] rrd;

   // frame end, first checks
   logic [2:0] early_stat;
   always_comb begin
      if (count_ff > mrs_pkg::COUNT_W'(FRAME_BYTES)) begin
         early_stat = mrs_pkg::STAT_OVERFLOW;
      end else if (count_ff < mrs_pkg::COUNT_W'(2) || count_ff < {1'b0, min_len_ff}) begin
         early_stat = mrs_pkg::STAT_SHORT;
      end else if (crc_ff != 16'h0000) begin
         early_stat = mrs_pkg::STAT_CRC;
      end else begin
         early_stat = mrs_pkg::STAT_OK;
      end
   end

   // header evaluation
   logic [3:0]  h_page;
   logic [11:0] h_off;
   logic [15:0] h_cnt;
   logic [7:0]  carried, eff_a, eff;
   logic [12:0] limit;
   logic [2:0]  eval_stat;
   logic        eval_write;
   always_comb begin
      h_page  = hdr_ff[2][7:4];
      h_off   = {hdr_ff[2][3:0], hdr_ff[3]};
      h_cnt   = {hdr_ff[4], hdr_ff[5]};
      carried = (count_ff >= mrs_pkg::COUNT_W'(9))
                ? 8'((count_ff - mrs_pkg::COUNT_W'(9)) >> 1) : 8'd0;
      limit   = 13'(PAGE_WORDS) - {1'b0, h_off};
      eff_a   = (h_cnt < {8'd0, carried}) ? h_cnt[7:0] : carried;
      eff     = ({5'd0, eff_a} > limit) ? limit[7:0] : eff_a;
      eval_write = 1'b0;
      if (hdr_ff[0] != slave_id_ff) begin
         eval_stat = mrs_pkg::STAT_ID;
      end else if (hdr_ff[1] == mrs_pkg::FC_READ_HOLDING ||
                   hdr_ff[1] == mrs_pkg::FC_READ_INPUT) begin
         eval_stat = mrs_pkg::STAT_OK;
      end else if (hdr_ff[1] != mrs_pkg::FC_WRITE_MULTI) begin
         eval_stat = mrs_pkg::STAT_FUNC;
      end else if (!(32'(h_page) < PAGES && page_en_ff[h_page])) begin
         eval_stat = mrs_pkg::STAT_UNMAPPED;
      end else if ({1'b0, h_off} >= 13'(PAGE_WORDS)) begin
         eval_stat = mrs_pkg::STAT_BEYOND;
      end else begin
         eval_stat  = mrs_pkg::STAT_OK;
         eval_write = (eff != 8'd0);
      end
   end

   // local access
   logic [3:0]      l_page;
   logic [11:0]     l_off;
   logic [2:0]      local_stat;
   logic [RA_W-1:0] l_ra;
   always_comb begin
      l_page = addr_ff[15:12];
      l_off  = addr_ff[11:0];
      l_ra   = RA_W'(int'(l_page) * PAGE_WORDS + int'(l_off));
      if (!(32'(l_page) < PAGES && page_en_ff[l_page])) begin
         local_stat = mrs_pkg::STAT_UNMAPPED;
      end else if ({1'b0, l_off} >= 13'(PAGE_WORDS)) begin
         local_stat = mrs_pkg::STAT_BEYOND;
      end else begin
         local_stat = mrs_pkg::STAT_OK;
      end
   end

   always_comb begin
      sts.in_op      = mrs_pkg::opcode_type'(req_opcode);
      sts.in_last    = req_last_of_frame;
      sts.early_bad  = (early_stat != mrs_pkg::STAT_OK);
      sts.eval_write = eval_write;
      sts.hdr_done   = (hidx_ff == 3'(mrs_pkg::HDR_BYTES - 1));
      sts.word_done  = (wleft_ff == mrs_pkg::WORDS_W'(1));
      sts.local_load = (local_stat == mrs_pkg::STAT_OK) && (op_ff == mrs_pkg::OP_LOAD);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // frame buffer
   logic frame_wr;
   assign frame_wr = cmd.accept && (req_opcode == mrs_pkg::OP_FRAME_BYTE) &&
                     (count_ff < mrs_pkg::COUNT_W'(FRAME_BYTES));

   mrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_wr),
      .wr_addr (count_ff[FA_W-1:0]),
      .wr_data (req_frame_byte),
      .rd_addr (cmd.hdr_rd ? FA_W'(hidx_ff) : ptr_ff),
      .rd_data (frd)
   );

   // register store
   logic reg_wr;
   assign reg_wr = cmd.word_wr || (cmd.local_op && local_stat == mrs_pkg::STAT_OK &&
                                   op_ff == mrs_pkg::OP_STORE);

   mrs_ram #(.WIDTH(16), .DEPTH(PAGES * PAGE_WORDS)) u_reg_ram (
      .clock   (clock),
      .wr_en   (reg_wr),
      .wr_addr (cmd.word_wr ? ra_ff : l_ra),
      .wr_data (cmd.word_wr ? {hi_ff, frd} : wword_ff),
      .rd_addr (l_ra),
      .rd_data (rrd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff  <= 8'd0;
         page_en_ff   <= 16'd0;
         min_len_ff   <= 8'd4;
         count_ff     <= '0;
         crc_ff       <= mrs_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               mrs_pkg::CSR_SLAVE_ID:      slave_id_ff <= csr_data[7:0];
               mrs_pkg::CSR_PAGE_ENABLE:   page_en_ff  <= csr_data;
               mrs_pkg::CSR_MIN_FRAME_LEN: min_len_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
         if (cmd.accept && req_opcode == mrs_pkg::OP_FRAME_BYTE) begin
            if (count_ff != mrs_pkg::COUNT_MAX) begin
               count_ff <= count_ff + 1'b1;
            end
            crc_ff <= mrs_pkg::crc_byte(crc_ff, req_frame_byte);
         end
         if (cmd.result_load && is_frame_ff) begin
            count_ff <= '0;
            crc_ff   <= mrs_pkg::CRC_INIT;
         end
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         is_frame_ff <= (req_opcode == mrs_pkg::OP_FRAME_BYTE);
         op_ff       <= mrs_pkg::opcode_type'(req_opcode);
         addr_ff     <= req_address;
         wword_ff    <= req_write_word;
      end
      if (cmd.check) begin
         hidx_ff <= 3'd0;
         stat_ff <= early_stat;
         word_ff <= 16'd0;
      end
      if (cmd.hdr_cap) begin
         hdr_ff[hidx_ff] <= ({6'd0, hidx_ff} < count_ff) ? frd : 8'd0;
         hidx_ff         <= hidx_ff + 3'd1;
      end
      if (cmd.eval) begin
         stat_ff  <= eval_stat;
         ptr_ff   <= FA_W'(7);
         ra_ff    <= RA_W'(int'(h_page) * PAGE_WORDS + int'(h_off));
         wleft_ff <= eff;
      end
      if (cmd.word_hi || cmd.word_lo) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
      if (cmd.word_lo) begin
         hi_ff <= frd;
      end
      if (cmd.word_wr) begin
         ra_ff    <= ra_ff + 1'b1;
         wleft_ff <= wleft_ff - 1'b1;
      end
      if (cmd.local_op) begin
         stat_ff <= local_stat;
         word_ff <= 16'd0;
      end
      if (cmd.load_cap) begin
         word_ff <= rrd;
      end
      if (cmd.result_load) begin
         rsp_stat_ff <= stat_ff;
         rsp_word_ff <= word_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_stat_ff;
   assign rsp_read_word = rsp_word_ff;

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.result_load && is_frame_ff) |=> (count_ff == '0 && crc_ff == mrs_pkg::CRC_INIT))
      else $error("frame state not cleared after frame result");
   a_word_left: assert property (@(posedge clock) disable iff (reset)
      cmd.word_wr |-> (wleft_ff != '0))
      else $error("register write with no words left");
   a_word_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_stat_ff == mrs_pkg::STAT_OK || rsp_word_ff == 16'd0))
      else $error("load word returned with error status");
endmodule
`default_nettype wire

/* sv/modbus_rtu_register_slave_top.sv */
// Top level of the RTU register slave: controller plus datapath.
// Depends on mrs_pkg, mrs_if, mrs_ram, mrs_ctrl and mrs_dp.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | dir | payload                                           | handshake
//  --------+-----+---------------------------------------------------+-----------
//  req_ch  | in  | opcode, frame_byte, last_of_frame, address, word  | valid/ready
//  rsp_ch  | out | status, read_word                                 | valid/ready
//  csr_ch  | in  | index, data                                       | valid/ready
//
//  A non-last frame byte keeps the controller idle; bytes may follow back to back.
//  A last byte whose length or CRC check fails goes straight to the result; else the
//  six header bytes are read in turn through the frame buffer's single read port,
//  then each stored word is written; local loads wait for read data, stores do not.
//  Reset (synchronous, active high) clears slave id, page map and byte count, sets
//  min length to 4 and CRC to FFFF; frame buffer and register store are left as they are.
//  req_ch is ready only while idle, so a transaction waits until the previous
//  result has entered the output register; rsp_ch stalls never lose a result,
//  and csr_ch is always ready.
//
module modbus_rtu_register_slave_top #(
   parameter int PAGES       = mrs_pkg::PAGES_DEFAULT,
   parameter int PAGE_WORDS  = mrs_pkg::PAGE_WORDS_DEFAULT,
   parameter int FRAME_BYTES = mrs_pkg::FRAME_BYTES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   mrs_req_if.sink   req_ch,
   mrs_rsp_if.source rsp_ch,
   mrs_csr_if.sink   csr_ch
);
   mrs_pkg::cmd_type cmd;
   mrs_pkg::sts_type sts;
   logic             req_ready;

   // config writes land directly in the registers: accept every transaction
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;

   mrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mrs_dp #(
      .PAGES       (PAGES),
      .PAGE_WORDS  (PAGE_WORDS),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_ch.opcode),
      .req_frame_byte    (req_ch.frame_byte),
      .req_last_of_frame (req_ch.last_of_frame),
      .req_address       (req_ch.address),
      .req_write_word    (req_ch.write_word),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_read_word     (rsp_ch.read_word),
      .csr_valid         (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data)
   );
endmodule
`default_nettype wire

/* tb/modbus_rtu_register_slave_top_tb.sv */
// Self-checking testbench for the RTU register slave: frames, local loads and stores.
// Depends on mrs_pkg, mrs_if and the top level modbus_rtu_register_slave_top.
`timescale 1ns / 1ps

// Predicts results for accepted transactions and checks what comes out.
class slave_scoreboard;
   logic [7:0]  slave_id;
   logic [15:0] page_enable;
   logic [7:0]  min_len;
   logic [7:0]  frame_buf [256];
   int          byte_count;
   logic [15:0] crc;
   logic [15:0] regs [4096];
   logic [18:0] pending_results [$];
   int          errors;

   function new();
      slave_id = 8'h00;
      page_enable = 16'h0000;
      min_len = 8'd4;
      byte_count = 0;
      crc = 16'hFFFF;
      errors = 0;
      foreach (regs[i]) regs[i] = 16'h0000;
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
   endfunction

   function void write_csr(logic [1:0] idx, logic [15:0] d);
      if (idx == mrs_pkg::CSR_SLAVE_ID) slave_id = d[7:0];
      else if (idx == mrs_pkg::CSR_PAGE_ENABLE) page_enable = d;
      else if (idx == mrs_pkg::CSR_MIN_FRAME_LEN) min_len = d[7:0];
   endfunction

   function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      c ^= {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function logic [7:0] hdr(int pos, int len);
      if (pos >= len || pos >= 256) return 8'h00;
      return frame_buf[pos];
   endfunction

   function logic [2:0] close_frame();
      int len, page, off, cnt, carried;
      logic [7:0] h2;
      len = byte_count;
      if (len > 256) return mrs_pkg::STAT_OVERFLOW;
      if (len < 2 || len < min_len) return mrs_pkg::STAT_SHORT;
      if (crc != 0) return mrs_pkg::STAT_CRC;
      if (hdr(0, len) != slave_id) return mrs_pkg::STAT_ID;
      if (hdr(1, len) == mrs_pkg::FC_READ_HOLDING || hdr(1, len) == mrs_pkg::FC_READ_INPUT)
         return mrs_pkg::STAT_OK;
      if (hdr(1, len) != mrs_pkg::FC_WRITE_MULTI) return mrs_pkg::STAT_FUNC;
      h2 = hdr(2, len);
      page = h2[7:4];
      if (!page_enable[page]) return mrs_pkg::STAT_UNMAPPED;
      off = {h2[3:0], hdr(3, len)};
      if (off >= 256) return mrs_pkg::STAT_BEYOND;
      cnt = {hdr(4, len), hdr(5, len)};
      carried = len >= 9 ? (len - 9) / 2 : 0;
      if (cnt > carried) cnt = carried;
      for (int i = 0; i < cnt && off + i < 256; i++)
         regs[page * 256 + off + i] = {hdr(7 + 2 * i, len), hdr(8 + 2 * i, len)};
      return mrs_pkg::STAT_OK;
   endfunction

   // Note one accepted request and queue its result, if it has one.
   function void note_request(logic [1:0] op, logic [7:0] b, logic last,
                              logic [15:0] addr, logic [15:0] w);
      logic [2:0]  st;
      logic [15:0] rw;
      rw = 16'h0000;
      if (op == mrs_pkg::OP_FRAME_BYTE) begin
         if (byte_count < 256) frame_buf[byte_count] = b;
         if (byte_count < 511) byte_count++;
         crc = crc_step(crc, b);
         if (!last) return;
         st = close_frame();
         byte_count = 0;
         crc = 16'hFFFF;
      end else if (op == mrs_pkg::OP_LOAD || op == mrs_pkg::OP_STORE) begin
         if (!page_enable[addr[15:12]]) st = mrs_pkg::STAT_UNMAPPED;
         else if (addr[11:0] >= 256) st = mrs_pkg::STAT_BEYOND;
         else begin
            st = mrs_pkg::STAT_OK;
            if (op == mrs_pkg::OP_LOAD) rw = regs[{addr[15:12], addr[7:0]}];
            else regs[{addr[15:12], addr[7:0]}] = w;
         end
      end else return;
      pending_results.push_back({st, rw});
   endfunction

   task check_result(logic [2:0] st, logic [15:0] rw);
      logic [18:0] e;
      if (pending_results.size() == 0) begin
         report("unexpected result", {st, rw}, 19'h00000);
         return;
      end
      e = pending_results.pop_front();
      if (st !== e[18:16]) report("status", {16'h0000, st}, {16'h0000, e[18:16]});
      if (rw !== e[15:0]) report("read_word", {3'b000, rw}, {3'b000, e[15:0]});
   endtask

   task report(string what, logic [18:0] got, logic [18:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
   endtask
endclass

module modbus_rtu_register_slave_top_tb;

   logic clock;
   logic reset;
   mrs_req_if req_ch();
   mrs_rsp_if rsp_ch();
   mrs_csr_if csr_ch();

   modbus_rtu_register_slave_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   slave_scoreboard sb;
   longint cycles;
   bit long_hold;          // set to ask the receiver for one long stall
   bit written [4096];     // register words written so far, by page and offset
   logic [15:0] map_now;   // page map as last programmed

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Abandon the run if it hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("[modbus_rtu_register_slave_top] ERROR");
         $finish;
      end
   end

   // Sample all three handshakes at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_request(req_ch.opcode, req_ch.frame_byte, req_ch.last_of_frame,
                         req_ch.address, req_ch.write_word);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.status, rsp_ch.read_word);
      if (!reset && csr_ch.valid && csr_ch.ready)
         sb.write_csr(csr_ch.index, csr_ch.data);
   end

   // Receiver: stall on a pattern of its own, with one long hold-off on request.
   initial begin
      int mode;
      rsp_ch.ready = 0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ch.ready <= 0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 40)) begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   int burst_left;

   // Offer one transaction, hold until accepted, then perhaps pause.
   task automatic send(logic [1:0] op, logic [7:0] b, logic last,
                       logic [15:0] addr, logic [15:0] w);
      req_ch.opcode <= op;
      req_ch.frame_byte <= b;
      req_ch.last_of_frame <= last;
      req_ch.address <= addr;
      req_ch.write_word <= w;
      req_ch.valid <= 1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   endtask

   // Send a frame with its CRC appended, low byte first; bad_crc flips one CRC bit.
   task automatic send_frame(logic [7:0] body [$], bit bad_crc);
      logic [15:0] c;
      c = 16'hFFFF;
      foreach (body[i]) c = sb.crc_step(c, body[i]);
      if (bad_crc) c ^= 16'h0001 << $urandom_range(0, 15);
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
      foreach (body[i])
         send(mrs_pkg::OP_FRAME_BYTE, body[i], i == body.size() - 1, 16'h0000, 16'h0000);
   endtask

   // Write-multiple frame; every word it stores is marked as readable.
   task automatic write_frame(logic [7:0] id, logic [15:0] start, int n, int cnt_field);
      logic [7:0] body [$];
      logic [15:0] w;
      body = {id, mrs_pkg::FC_WRITE_MULTI, start[15:8], start[7:0], 8'(cnt_field >> 8),
              8'(cnt_field), 8'(2 * n)};
      for (int i = 0; i < n; i++) begin
         w = 16'($urandom);
         body.push_back(w[15:8]);
         body.push_back(w[7:0]);
      end
      if (id == sb.slave_id && map_now[start[15:12]] && start[11:0] < 256 &&
          2 * n + 9 >= sb.min_len)
         for (int i = 0; i < n && i < cnt_field && start[11:0] + i < 256; i++)
            written[{start[15:12], 8'(start[7:0] + i)}] = 1;
      send_frame(body, 0);
   endtask

   // Load that never touches an unwritten word of a mapped page.
   task automatic safe_load(logic [15:0] a);
      if (map_now[a[15:12]] && a[11:0] < 256 && !written[{a[15:12], a[7:0]}]) begin
         send(mrs_pkg::OP_STORE, 8'h00, 1'b0, a, 16'($urandom));
         written[{a[15:12], a[7:0]}] = 1;
      end
      send(mrs_pkg::OP_LOAD, 8'($urandom), 1'($urandom), a, 16'($urandom));
   endtask

   task automatic store(logic [15:0] a, logic [15:0] w);
      if (map_now[a[15:12]] && a[11:0] < 256) written[{a[15:12], a[7:0]}] = 1;
      send(mrs_pkg::OP_STORE, 8'($urandom), 1'($urandom), a, w);
   endtask

   // Drain everything outstanding, then let the block settle before a write.
   task automatic write_reg(logic [1:0] idx, logic [15:0] d);
      req_ch.valid <= 0;
      while (sb.pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_ch.index <= idx;
      csr_ch.data <= d;
      csr_ch.valid <= 1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 0;
      if (idx == mrs_pkg::CSR_PAGE_ENABLE) map_now = d;
   endtask

   function automatic logic [15:0] pick_addr();
      logic [15:0] a;
      a = 16'($urandom);
      if ($urandom_range(0, 3) != 0) a[11:8] = 4'h0;
      return a;
   endfunction

   initial begin
      logic [7:0] body [$];
      logic [7:0] id;
      int n, kind, limit;
      sb = new();
      cycles = 0;
      long_hold = 0;
      burst_left = 0;
      map_now = 0;
      req_ch.valid = 0;
      req_ch.opcode = mrs_pkg::OP_FRAME_BYTE;
      req_ch.frame_byte = 0;
      req_ch.last_of_frame = 0;
      req_ch.address = 0;
      req_ch.write_word = 0;
      csr_ch.valid = 0;
      csr_ch.index = mrs_pkg::CSR_SLAVE_ID;
      csr_ch.data = 0;
      reset = 1;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: unmapped page, short frames, then every register written.
      send(mrs_pkg::OP_LOAD, 8'h00, 1'b0, 16'h0000, 16'h0000);
      send(mrs_pkg::OP_FRAME_BYTE, 8'hFF, 1'b1, 16'h0000, 16'h0000);  // one-byte frame
      send(mrs_pkg::OP_NONE, 8'hAA, 1'b1, 16'hFFFF, 16'hFFFF);        // unused opcode
      write_reg(mrs_pkg::CSR_SLAVE_ID, 16'h0011);
      write_reg(mrs_pkg::CSR_PAGE_ENABLE, 16'h8001);
      write_reg(mrs_pkg::CSR_MIN_FRAME_LEN, 16'h0000);
      send(mrs_pkg::OP_FRAME_BYTE, 8'h11, 1'b1, 16'h0000, 16'h0000);  // still too short
      store(16'h0000, 16'hFFFF);
      store(16'hF0FF, 16'h0000);
      safe_load(16'h0000);
      safe_load(16'hF0FF);
      store(16'h0100, 16'h1234);                               // offset beyond page
      safe_load(16'hFFFF);
      store(16'h7000, 16'h5555);                               // disabled page
      write_frame(8'h11, 16'h00FE, 4, 4);                      // runs past page end
      safe_load(16'h00FF);
      write_frame(8'h11, 16'h0010, 3, 100);                    // count capped
      write_frame(8'h11, 16'h0010, 3, 0);
      write_frame(8'h22, 16'h0010, 1, 1);                      // id mismatch
      write_frame(8'h11, 16'h2000, 1, 1);                      // page unmapped
      write_frame(8'h11, 16'h0300, 1, 1);                      // offset beyond page
      body = {8'h11, mrs_pkg::FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01};
      send_frame(body, 0);
      body = {8'h11, mrs_pkg::FC_READ_INPUT, 8'h00, 8'h00, 8'h00, 8'h01};
      send_frame(body, 0);
      body = {8'h11, 8'h06, 8'h00, 8'h00, 8'h00, 8'h01};
      send_frame(body, 0);
      body = {8'h11, mrs_pkg::FC_WRITE_MULTI, 8'h00, 8'h00};
      send_frame(body, 1);
      body = {8'h11};
      send_frame(body, 0);                                     // header cut short
      body.delete();
      for (int i = 0; i < 300; i++) body.push_back(8'($urandom));
      send(mrs_pkg::OP_FRAME_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000);
      foreach (body[i])                                        // overflow
         send(mrs_pkg::OP_FRAME_BYTE, body[i], i == 299, 16'h0000, 16'h0000);
      write_reg(mrs_pkg::CSR_MIN_FRAME_LEN, 16'h00FF);
      write_frame(8'h11, 16'h0000, 2, 2);                      // below min length

      // Random phases under several register settings.
      for (int ph = 0; ph < 6; ph++) begin
         id = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom);
         write_reg(mrs_pkg::CSR_SLAVE_ID, {8'h00, id});
         write_reg(mrs_pkg::CSR_PAGE_ENABLE, ph == 1 ? 16'hFFFF : 16'($urandom) | 16'h0001);
         write_reg(mrs_pkg::CSR_MIN_FRAME_LEN,
                   ph == 2 ? 16'h0002 : 16'($urandom_range(0, 12)));
         if (ph == 3) long_hold = 1;          // fill the block while output is held
         limit = 0;
         while (limit < 115) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 123) : $urandom_range(0, 6);
               write_frame($urandom_range(0, 7) == 0 ? 8'($urandom) : id,
                           pick_addr() & 16'hF0FF |
                           ($urandom_range(0, 7) == 0 ? 16'h0F00 : 16'h0000),
                           n, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : n);
               limit += 2 * n + 9;
            end else if (kind < 6) begin
               body.delete();
               n = $urandom_range(0, 10);
               for (int i = 0; i < n; i++) body.push_back(8'($urandom));
               if (n > 0 && $urandom_range(0, 1)) body[0] = id;
               if (n > 1 && $urandom_range(0, 1)) body[1] = 8'($urandom_range(3, 4));
               send_frame(body, $urandom_range(0, 3) == 0);
               limit += n + 2;
            end else if (kind < 8) begin
               safe_load(pick_addr());
               limit++;
            end else begin
               store(pick_addr(), 16'($urandom));
               limit++;
            end
         end
      end

      req_ch.valid <= 0;
      while (sb.pending_results.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("[modbus_rtu_register_slave_top] OK");
      else
         $display("[modbus_rtu_register_slave_top] ERROR");
      $finish;
   end
endmodule

/* files.f */
sv/mrs_pkg.sv
sv/mrs_if.sv
sv/mrs_ram.sv
sv/mrs_ctrl.sv
sv/mrs_dp.sv
sv/modbus_rtu_register_slave_top.sv
tb/modbus_rtu_register_slave_top_tb.sv
